// ===== rtl/vsd_pkg.sv =====
// shared types and constants for the varint stream decoder
// no dependencies; imported by every module of the block
package vsd_pkg;

   localparam int CodeByteWidth = 8;
   localparam int ValueWidth    = 64;
   localparam int LengthWidth   = 4;
   localparam int ModeWidth     = 3;
   localparam int CsrAddrWidth  = 3;
   localparam int CsrDataWidth  = 32;

   typedef enum logic [ModeWidth-1:0] {
      MODE_U16_7BIT  = 3'd0,
      MODE_U32_7BIT  = 3'd1,
      MODE_U64_7BIT  = 3'd2,
      MODE_U32_6BIT  = 3'd3,
      MODE_U64_6BIT  = 3'd4
   } mode_type;

   localparam logic [ModeWidth-1:0] ModeReset = MODE_U64_7BIT;

   // register index of format_mode
   localparam logic [0:0] RegFormatMode = 1'b0;

   localparam logic [CodeByteWidth-1:0] NullByte  = 8'h80;
   localparam logic [CodeByteWidth-1:0] Low7Mask  = 8'h7F;
   localparam logic [CodeByteWidth-1:0] Low6Mask  = 8'h3F;

   localparam logic [LengthWidth-1:0] LastPos16   = 4'd2;
   localparam logic [LengthWidth-1:0] LastPos32   = 4'd4;
   localparam logic [LengthWidth-1:0] LastPos64   = 4'd8;
   localparam logic [LengthWidth-1:0] LastPos6u32 = 4'd5;
   localparam logic [LengthWidth-1:0] LastPos6u64 = 4'd10;
   localparam logic [LengthWidth-1:0] WidePos     = 4'd7;

   typedef struct packed {
      logic                   emit;
      logic [ValueWidth-1:0]  value;
      logic                   null_flag;
      logic [LengthWidth-1:0] length;
      logic [ValueWidth-1:0]  acc_next;
      logic [LengthWidth-1:0] pos_next;
   } step_type;

endpackage

// ===== rtl/vsd_csr.sv =====
// apb-style register port holding format_mode
// depends on vsd_pkg
module vsd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vsd_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [vsd_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [vsd_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready,
   output logic [vsd_pkg::ModeWidth-1:0]     mode,
   output logic                              mode_write
);
   import vsd_pkg::*;

   logic [ModeWidth-1:0] mode_ff;
   logic [ModeWidth-1:0] mode_in;
   logic                 hit;

   assign hit        = (csr_paddr[CsrAddrWidth-1:2] == RegFormatMode);
   assign mode_write = csr_psel && csr_penable && csr_pwrite && hit;
   assign mode_in    = mode_write ? csr_pwdata[ModeWidth-1:0] : mode_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? {{(CsrDataWidth-ModeWidth){1'b0}}, mode_ff} : '0;
   assign mode       = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeReset;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ===== rtl/vsd_step.sv =====
// combinational decode of one code byte against the current accumulator
// depends on vsd_pkg
module vsd_step (
   input  logic [vsd_pkg::ModeWidth-1:0]     mode,
   input  logic [vsd_pkg::ValueWidth-1:0]    acc,
   input  logic [vsd_pkg::LengthWidth-1:0]   pos,
   input  logic [vsd_pkg::CodeByteWidth-1:0] code_byte,
   output vsd_pkg::step_type                 step
);
   import vsd_pkg::*;

   logic [ValueWidth-1:0]  width_mask;
   logic [LengthWidth-1:0] last_pos;
   logic                   seven_bit;
   logic                   at_last;
   logic                   is_null;
   logic [ValueWidth-1:0]  acc7;
   logic [ValueWidth-1:0]  acc6;
   logic [ValueWidth-1:0]  whole;
   logic                   wide_shift;

   always_comb begin
      case (mode)
         MODE_U16_7BIT: begin
            last_pos = LastPos16;   width_mask = {{48{1'b0}}, {16{1'b1}}}; seven_bit = 1'b1;
         end
         MODE_U32_7BIT: begin
            last_pos = LastPos32;   width_mask = {{32{1'b0}}, {32{1'b1}}}; seven_bit = 1'b1;
         end
         MODE_U32_6BIT: begin
            last_pos = LastPos6u32; width_mask = {{32{1'b0}}, {32{1'b1}}}; seven_bit = 1'b0;
         end
         MODE_U64_6BIT: begin
            last_pos = LastPos6u64; width_mask = '1;                       seven_bit = 1'b0;
         end
         default: begin
            last_pos = LastPos64;   width_mask = '1;                       seven_bit = 1'b1;
         end
      endcase
   end

   assign at_last    = (pos >= last_pos);
   assign is_null    = (mode == MODE_U32_7BIT) && (pos == '0) && (code_byte == NullByte);
   assign whole      = acc | {{(ValueWidth-CodeByteWidth){1'b0}}, code_byte};
   assign acc7       = acc | {{(ValueWidth-CodeByteWidth){1'b0}}, code_byte & Low7Mask};
   assign acc6       = acc | {{(ValueWidth-CodeByteWidth){1'b0}}, code_byte & Low6Mask};
   assign wide_shift = (last_pos == LastPos64) && (pos == WidePos);

   always_comb begin
      step.null_flag = 1'b0;
      step.length    = pos + 4'd1;
      if (seven_bit) begin
         if (is_null) begin
            step.emit      = 1'b1;
            step.value     = '0;
            step.null_flag = 1'b1;
         end else begin
            step.emit  = at_last || !code_byte[7];
            step.value = whole & width_mask;
         end
         step.acc_next = wide_shift ? (acc7 << 8) : (acc7 << 7);
      end else begin
         step.emit     = at_last || code_byte[6];
         step.value    = acc6 & width_mask;
         step.acc_next = acc6 << 6;
      end
      step.pos_next = pos + 4'd1;
      if (step.emit) begin
         step.acc_next = '0;
         step.pos_next = '0;
      end
   end

endmodule

// ===== rtl/varint_stream_decoder_top.sv =====
// Byte-serial variable-length integer decoder. One code byte is taken per
// cycle while no stalled result holds it back: a request is captured in an
// input register, decoded by a single mask/shift/or stage against the
// accumulator and, when the byte closes a code, the result is written to an
// output register. Sustained rate is one byte per clock. A stalled result
// stops new bytes only when the byte in the input register would itself
// close a code. format_mode (address 0) selects the format; any write to
// it abandons a partly received code. Configure only while idle.
// depends on vsd_pkg, vsd_csr and vsd_step
module varint_stream_decoder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [vsd_pkg::CodeByteWidth-1:0]   req_code_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [vsd_pkg::ValueWidth-1:0]      rsp_decoded_value,
   output logic                                rsp_null_flag,
   output logic [vsd_pkg::LengthWidth-1:0]     rsp_code_length,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vsd_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [vsd_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [vsd_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import vsd_pkg::*;

   logic [ModeWidth-1:0]     mode;
   logic                     mode_write;
   step_type                 step;

   logic                     in_valid_ff, in_valid_in;
   logic [CodeByteWidth-1:0] in_byte_ff, in_byte_in;
   logic [ValueWidth-1:0]    acc_ff, acc_in;
   logic [LengthWidth-1:0]   pos_ff, pos_in;
   logic                     out_valid_ff, out_valid_in;
   logic [ValueWidth-1:0]    out_value_ff, out_value_in;
   logic                     out_null_ff, out_null_in;
   logic [LengthWidth-1:0]   out_len_ff, out_len_in;
   logic                     fire;
   logic                     load_out;

   vsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mode        (mode),
      .mode_write  (mode_write)
   );

   vsd_step u_step (
      .mode      (mode),
      .acc       (acc_ff),
      .pos       (pos_ff),
      .code_byte (in_byte_ff),
      .step      (step)
   );

   assign fire      = in_valid_ff && (!step.emit || !out_valid_ff || rsp_ready);
   assign load_out  = fire && step.emit;
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_null_in  = out_null_ff;
      out_len_in   = out_len_ff;
      if (fire) begin
         in_valid_in = 1'b0;
         acc_in      = step.acc_next;
         pos_in      = step.pos_next;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_code_byte;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
         out_value_in = step.value;
         out_null_in  = step.null_flag;
         out_len_in   = step.length;
      end
      // a mode write drops any code in progress
      if (mode_write) begin
         acc_in = '0;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
      end
      in_byte_ff   <= in_byte_in;
      out_value_ff <= out_value_in;
      out_null_ff  <= out_null_in;
      out_len_ff   <= out_len_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_decoded_value = out_value_ff;
   assign rsp_null_flag     = out_null_ff;
   assign rsp_code_length   = out_len_ff;

   a_null_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_null_flag |-> rsp_decoded_value == '0 && rsp_code_length == 4'd1)
      else $error("null marker with non-zero value or length");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LastPos6u64)
      else $error("byte position beyond longest code");

   a_write_clears: assert property (@(posedge clock) disable iff (reset)
      mode_write |=> pos_ff == '0 && acc_ff == '0)
      else $error("mode write did not drop code in progress");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_code_length != '0 && rsp_code_length <= 4'd11)
      else $error("code length out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !load_out)
      else $error("pending request overwritten");

endmodule
